### hw/rtl/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg: shared constants for the bitcrusher hold quantizer
// Widths, register indexes and quantizer limits that are used by the
// channel interfaces and by the top level.
// ----------------------------------------------------------------------------
package bhq_pkg;

    // Default sample width, signed fixed point Q1.(W-1).
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration register widths and port shape.
    localparam int BIT_DEPTH_W = 5;
    localparam int HOLD_W      = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FACTOR = 1'd1;

    // Reset values of the registers.
    localparam logic [BIT_DEPTH_W-1:0] BIT_DEPTH_RST   = 5'd16;
    localparam logic [HOLD_W-1:0]      HOLD_FACTOR_RST = 8'd1;

    // Quantizer depth limits; the level count fits in LEVEL_W bits.
    localparam logic [BIT_DEPTH_W-1:0] DEPTH_MIN = 5'd2;
    localparam logic [BIT_DEPTH_W-1:0] DEPTH_MAX = 5'd16;
    localparam int LEVEL_W = 15;
    localparam int SHIFT_W = 4;

endpackage

### hw/rtl/bhq_in_if.sv
// ----------------------------------------------------------------------------
// bhq_in_if: sample input channel
// Valid/ready channel that carries one input audio sample per item.
// ----------------------------------------------------------------------------
interface bhq_in_if #(
    parameter int SAMPLE_WIDTH = bhq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

### hw/rtl/bhq_out_if.sv
// ----------------------------------------------------------------------------
// bhq_out_if: crushed sample output channel
// Valid/ready channel that carries one crushed sample and its fresh flag.
// ----------------------------------------------------------------------------
interface bhq_out_if #(
    parameter int SAMPLE_WIDTH = bhq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           fresh;

    modport source (output valid, output sample_out, output fresh, input ready);
    modport sink   (input valid, input sample_out, input fresh, output ready);
endinterface

### hw/rtl/bitcrusher_hold_quantizer.sv
// ----------------------------------------------------------------------------
// bitcrusher_hold_quantizer: sample-rate and bit-depth reduction
// A picked (fresh) item runs SAMPLE_WIDTH steps of the bit-serial restoring
// divider (one quotient bit per cycle) and is then loaded into the output
// register once that is free; a held item is loaded there as it is accepted.
// One item is in work at a time, so a fresh item finishes before the next is
// taken; held items go one per cycle while the output register is free.
// Reset (synchronous, active low) sets bit_depth 16, hold_factor 1, and clears
// the hold counter, the held value and the output valid flag.
// ----------------------------------------------------------------------------
module bitcrusher_hold_quantizer #(
    parameter int SAMPLE_WIDTH = bhq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bhq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bhq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bhq_in_if.sink                           i_in,
    bhq_out_if.source                        o_out
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int LW   = bhq_pkg::LEVEL_W;
    localparam int SW   = bhq_pkg::SHIFT_W;
    localparam int PW   = W + LW + 1;   // |x| * M + FS/2
    localparam int NW   = LW + W + 1;   // q * 2^W + M
    localparam int DW   = LW + 2;       // divisor 2M and partial remainder
    localparam int CW   = $clog2(W);
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                        r_state;
    logic [bhq_pkg::BIT_DEPTH_W-1:0] r_bit_depth;
    logic [bhq_pkg::HOLD_W-1:0]    r_hold_factor;
    logic [bhq_pkg::HOLD_W-1:0]    r_hold_count;
    logic [W-1:0]                  r_held_value;
    logic                          r_neg;
    logic [DW-1:0]                 r_rem;
    logic [DW-1:0]                 r_div;
    logic [W-1:0]                  r_sr;
    logic [CW-1:0]                 r_step;
    logic                          r_out_valid;
    logic [W-1:0]                  r_out_sample;
    logic                          r_out_fresh;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_out_load;
    logic                          w_hold_write;
    logic                          w_neg;
    logic [W:0]                    w_mag;
    logic [bhq_pkg::BIT_DEPTH_W-1:0] w_depth;
    logic [SW-1:0]                 w_shift;
    logic [LW:0]                   w_m_ext;
    logic [LW-1:0]                 w_m;
    logic [PW-1:0]                 w_prod;
    logic [LW-1:0]                 w_q;
    logic [NW-1:0]                 w_num;
    logic [DW-1:0]                 w_trial;
    logic                          w_ge;
    logic [W-1:0]                  w_final;
    logic [bhq_pkg::HOLD_W:0]      n_count_inc;
    logic [bhq_pkg::HOLD_W-1:0]    n_hold_count;
    logic [DW-1:0]                 n_rem;

    // Handshake: a held item needs a free output register, a fresh one only
    // needs the divider to be idle.
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && ((r_hold_count == '0) || w_out_free);
    assign w_accept   = i_in.valid && i_in.ready;

    // The output register takes a held item at once or a finished division.
    assign w_out_load = (w_accept && (r_hold_count != '0))
                     || ((r_state == ST_DONE) && w_out_free);

    // A hold factor write clears the counter and wins over an item's advance.
    assign w_hold_write = i_cfg_we && (i_cfg_idx == bhq_pkg::REG_HOLD_FACTOR);

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.fresh      = r_out_fresh;

    // Sign and magnitude of the input; the most negative sample gives FS.
    assign w_neg = i_in.sample_in[W-1];
    assign w_mag = w_neg ? ((~{1'b1, i_in.sample_in}) + (W+1)'(1))
                         : {1'b0, i_in.sample_in};

    // Clamp the bit depth and form the level count M = 2^(d-1) - 1.
    always_comb begin
        if (r_bit_depth < bhq_pkg::DEPTH_MIN) begin
            w_depth = bhq_pkg::DEPTH_MIN;
        end else if (r_bit_depth > bhq_pkg::DEPTH_MAX) begin
            w_depth = bhq_pkg::DEPTH_MAX;
        end else begin
            w_depth = r_bit_depth;
        end
    end
    assign w_shift = SW'(w_depth - bhq_pkg::BIT_DEPTH_W'(1));
    assign w_m_ext = ((LW+1)'(1) << w_shift) - (LW+1)'(1);
    assign w_m     = w_m_ext[LW-1:0];

    // Level index q = (|x| * M + FS/2) / FS, with M * |x| as shift minus value.
    assign w_prod = (PW'(w_mag) << w_shift) - PW'(w_mag) + (PW'(1) << (W - 2));
    assign w_q    = w_prod[W-1 +: LW];

    // Dividend q * 2^W + M; its upper part seeds the remainder, the lower W
    // bits are shifted in one per cycle.
    assign w_num = (NW'(w_q) << W) + NW'(w_m);

    // One restoring division step.
    assign w_trial = {r_rem[DW-2:0], r_sr[W-1]};
    assign w_ge    = (w_trial >= r_div);
    assign n_rem   = w_ge ? (w_trial - r_div) : w_trial;

    // Rescaled magnitude back to signed, with positive full scale saturated.
    always_comb begin
        if (r_neg) begin
            w_final = (~r_sr) + W'(1);
        end else if (r_sr[W-1]) begin
            w_final = {1'b0, {(W-1){1'b1}}};
        end else begin
            w_final = r_sr;
        end
    end

    // Hold counter advance, wrapping at the hold factor.
    assign n_count_inc  = {1'b0, r_hold_count} + (bhq_pkg::HOLD_W+1)'(1);
    assign n_hold_count = (n_count_inc >= {1'b0, r_hold_factor}) ? '0
                        : n_count_inc[bhq_pkg::HOLD_W-1:0];

    // Sequencer, divider registers, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_bit_depth   <= bhq_pkg::BIT_DEPTH_RST;
            r_hold_factor <= bhq_pkg::HOLD_FACTOR_RST;
            r_hold_count  <= '0;
            r_held_value  <= '0;
            r_out_valid   <= 1'b0;
            r_step        <= '0;
        end else begin
            // The output valid flag is set by a new result and cleared once
            // the result is taken.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bhq_pkg::REG_BIT_DEPTH: begin
                        r_bit_depth <= i_cfg_data[bhq_pkg::BIT_DEPTH_W-1:0];
                    end
                    bhq_pkg::REG_HOLD_FACTOR: begin
                        r_hold_factor <= i_cfg_data[bhq_pkg::HOLD_W-1:0];
                        r_hold_count  <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (!w_hold_write) begin
                            r_hold_count <= n_hold_count;
                        end
                        if (r_hold_count == '0) begin
                            r_neg   <= w_neg;
                            r_rem   <= DW'(w_num[NW-1:W]);
                            r_sr    <= w_num[W-1:0];
                            r_div   <= DW'({w_m, 1'b0});
                            r_step  <= '0;
                            r_state <= ST_DIV;
                        end else begin
                            r_out_sample <= r_held_value;
                            r_out_fresh  <= 1'b0;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_sr   <= {r_sr[W-2:0], w_ge};
                    r_step <= r_step + CW'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_held_value <= w_final;
                        r_out_sample <= w_final;
                        r_out_fresh  <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // No item is taken while the divider is working.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_in.ready)
        else $error("item accepted while divider busy");

    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    // A held item shows up as a non-fresh result in the next cycle.
    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_hold_count != '0)) |=> (o_out.valid && !o_out.fresh))
        else $error("held item result missing");

    // A finished division always lands in the output register as fresh.
    a_fresh_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && w_out_free) |=> (o_out.valid && o_out.fresh))
        else $error("fresh result missing");
`endif

endmodule

### tb/sv/bitcrusher_hold_quantizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcrusher_hold_quantizer_tb: self-checking testbench for the bitcrusher
// A short stimulus table covers the depth clamps, rounding halves, full-scale
// saturation and the hold counter. Random phases follow, each with a fresh
// register setting. Every output item is checked against its table value or
// an in-bench model of the quantizer and the sample-and-hold counter.
// ----------------------------------------------------------------------------
module bitcrusher_hold_quantizer_tb;

    localparam int      SW           = bhq_pkg::SAMPLE_WIDTH_DEF;
    localparam longint  FS           = longint'(1) << (SW - 1);
    localparam int      ITEMS_TOTAL  = 1250;
    localparam int      SETTLE_CYC   = SW + 4;
    localparam int      HOLDOFF_CYC  = 300;
    localparam int      HOLDOFF_AT   = 500;
    localparam int      IDLE_PCT     = 21;
    localparam int      REPORT_LIMIT = 10;

    typedef logic signed [SW-1:0]            t_sample;
    typedef logic [bhq_pkg::CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic [bhq_pkg::CFG_DATA_W-1:0]  t_cfg_data;

    typedef struct packed {
        t_sample value;
        logic    fresh;
    } t_crushed;

    typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_KNOWN} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_cfg_idx  idx;
        t_cfg_data data;
        t_sample   x;
        t_crushed  want;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    bhq_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    bhq_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    bitcrusher_hold_quantizer #(.SAMPLE_WIDTH(SW)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Shadow copy of the block's registers and hold state.
    logic [bhq_pkg::BIT_DEPTH_W-1:0] depth_q;
    logic [bhq_pkg::HOLD_W-1:0]      hold_factor_q;
    int                              hold_count_q;
    t_sample                         held_q;

    // Pending outputs, oldest first, and run statistics.
    t_crushed  crushed_q[$];
    t_stim_row plan[$];
    t_crushed  want_now;
    int        fault_count   = 0;
    int        items_sent    = 0;
    int        fresh_seen    = 0;
    int        held_seen     = 0;
    int        reg_writes    = 0;
    int        phase_count   = 0;
    bit        calm          = 1'b0;

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Generous ceiling on the whole run.
    initial begin
        #5_000_000;
        $display("Timeout: %0d output items still pending", crushed_q.size());
        $display("Test completed with failures");
        $finish;
    end

    // Depth values outside the supported range clamp to the nearest end.
    function automatic int effective_depth(logic [bhq_pkg::BIT_DEPTH_W-1:0] d);
        if (d < bhq_pkg::DEPTH_MIN) return int'(bhq_pkg::DEPTH_MIN);
        if (d > bhq_pkg::DEPTH_MAX) return int'(bhq_pkg::DEPTH_MAX);
        return int'(d);
    endfunction

    // Quantize on the magnitude with halves away from zero, rescale, then
    // restore the sign and saturate at positive full scale.
    function automatic t_sample crush_value(t_sample x,
                                            logic [bhq_pkg::BIT_DEPTH_W-1:0] d);
        longint mag, levels, q, r;
        bit     neg;
        neg    = x[SW-1];
        mag    = neg ? -longint'(x) : longint'(x);
        levels = (longint'(1) << (effective_depth(d) - 1)) - 1;
        q      = (mag * levels + FS / 2) / FS;
        r      = (2 * q * FS + levels) / (2 * levels);
        if (!neg) begin
            if (r > FS - 1) r = FS - 1;
            return t_sample'(r);
        end
        if (r > FS) r = FS;
        return t_sample'(-r);
    endfunction

    // Advance the hold counter by one item and return the output it causes.
    function automatic t_crushed step_hold(t_sample x);
        t_crushed res;
        int       factor;
        factor    = (hold_factor_q == '0) ? 1 : int'(hold_factor_q);
        res.fresh = 1'b0;
        if (hold_count_q == 0) begin
            held_q    = crush_value(x, depth_q);
            res.fresh = 1'b1;
        end
        hold_count_q++;
        if (hold_count_q >= factor) hold_count_q = 0;
        res.value = held_q;
        return res;
    endfunction

    function automatic void add_row(t_row_kind kind, t_cfg_idx idx, t_cfg_data data,
                                    int x, int value, logic fresh);
        t_stim_row row;
        row.kind       = kind;
        row.idx        = idx;
        row.data       = data;
        row.x          = t_sample'(x);
        row.want.value = t_sample'(value);
        row.want.fresh = fresh;
        plan.push_back(row);
    endfunction

    // Random sample: extremes, points next to a rounding half for the
    // current depth, small values near zero, or the full range.
    function automatic t_sample pick_sample();
        longint levels, k, mag;
        t_sample s;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: s = t_sample'(FS);
                    1: s = t_sample'(FS - 1);
                    2: s = '0;
                    3: s = t_sample'(-1);
                    default: s = t_sample'(1);
                endcase
            end
            1: begin
                levels = (longint'(1) << (effective_depth(depth_q) - 1)) - 1;
                k      = $urandom_range(0, int'(levels) - 1);
                mag    = ((2 * k + 1) * (FS / 2)) / levels + $urandom_range(0, 2) - 1;
                if (mag > FS - 1) mag = FS - 1;
                if (mag < 0) mag = 0;
                s = $urandom_range(0, 1) ? t_sample'(-mag) : t_sample'(mag);
            end
            2, 3: s = t_sample'(longint'($urandom_range(0, 1023)) - 512);
            default: s = t_sample'($urandom());
        endcase
        return s;
    endfunction

    task automatic note_fault(string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("%s", msg);
    endtask

    // Offer one item, with random gaps before it outside the calm phases, and log
    // its expected output at the edge where it is taken.
    task automatic push_sample(t_sample x, bit known, t_crushed want);
        t_crushed pred;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = step_hold(x);
        crushed_q.push_back(known ? want : pred);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every pending output item has arrived.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (crushed_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // One register write, followed by a quiet gap with the write enable low.
    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == bhq_pkg::REG_BIT_DEPTH) begin
            depth_q = data[bhq_pkg::BIT_DEPTH_W-1:0];
        end else if (idx == bhq_pkg::REG_HOLD_FACTOR) begin
            hold_factor_q = data[bhq_pkg::HOLD_W-1:0];
            hold_count_q  = 0;
        end
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Output checker: every accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (crushed_q.size() == 0) begin
                note_fault($sformatf("Unexpected output item: sample %0d fresh %0b",
                                     out_ch.sample_out, out_ch.fresh));
            end else begin
                want_now = crushed_q.pop_front();
                if (out_ch.sample_out !== want_now.value || out_ch.fresh !== want_now.fresh)
                    note_fault($sformatf("Mismatch: expected sample %0d fresh %0b, got %0d %0b",
                                         want_now.value, want_now.fresh,
                                         out_ch.sample_out, out_ch.fresh));
                if (want_now.fresh) fresh_seen++;
                else held_seen++;
            end
        end
    end

    // Output side: random stalls, one long hold-off that backs up the input,
    // and no stalls while the calm phases run.
    initial begin
        int stall_left;
        bit holdoff_done;
        stall_left   = 0;
        holdoff_done = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!holdoff_done && items_sent >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                stall_left   = HOLDOFF_CYC - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        logic [bhq_pkg::BIT_DEPTH_W-1:0] depth_sel;
        t_cfg_data                       cfg;
        int                              n_items;
        int                              which;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        depth_q         = bhq_pkg::BIT_DEPTH_RST;
        hold_factor_q   = bhq_pkg::HOLD_FACTOR_RST;
        hold_count_q    = 0;
        held_q          = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Values after reset: zero, both full-scale ends.
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, 0, 0, 1'b1);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, -32768, -32768, 1'b1);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, 32767, 32767, 1'b1);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 12345, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, -1, 0, 1'b0);
        // Two-bit depth: saturation and halves rounded away from zero.
        add_row(ROW_WRITE, bhq_pkg::REG_BIT_DEPTH, 8'h02, 0, 0, 1'b0);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, 32767, 32767, 1'b1);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, 16384, 32767, 1'b1);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, 16383, 0, 1'b1);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, -16384, -32768, 1'b1);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, -16383, 0, 1'b1);
        // Depths below two act as two; above sixteen act as sixteen.
        add_row(ROW_WRITE, bhq_pkg::REG_BIT_DEPTH, 8'h00, 0, 0, 1'b0);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, 16384, 32767, 1'b1);
        add_row(ROW_WRITE, bhq_pkg::REG_BIT_DEPTH, 8'hE1, 0, 0, 1'b0);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, -20000, -32768, 1'b1);
        add_row(ROW_WRITE, bhq_pkg::REG_BIT_DEPTH, 8'hFF, 0, 0, 1'b0);
        add_row(ROW_KNOWN, bhq_pkg::REG_BIT_DEPTH, '0, -32768, -32768, 1'b1);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 1000, 0, 1'b0);
        add_row(ROW_WRITE, bhq_pkg::REG_BIT_DEPTH, 8'h08, 0, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 1000, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, -777, 0, 1'b0);
        // Hold factor zero acts as one; then a period of three.
        add_row(ROW_WRITE, bhq_pkg::REG_HOLD_FACTOR, 8'h00, 0, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 5, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 6, 0, 1'b0);
        add_row(ROW_WRITE, bhq_pkg::REG_HOLD_FACTOR, 8'h03, 0, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 100, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 200, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 300, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 400, 0, 1'b0);
        // A write in mid-period clears the counter, so the next item is fresh.
        add_row(ROW_WRITE, bhq_pkg::REG_HOLD_FACTOR, 8'hFF, 0, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 500, 0, 1'b0);
        add_row(ROW_ITEM,  bhq_pkg::REG_BIT_DEPTH, '0, 600, 0, 1'b0);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE: begin
                    settle();
                    write_reg(plan[i].idx, plan[i].data);
                end
                ROW_KNOWN: push_sample(plan[i].x, 1'b1, plan[i].want);
                default:   push_sample(plan[i].x, 1'b0, '0);
            endcase
        end

        // Random phases; each drains the block before its register writes.
        while (items_sent < ITEMS_TOTAL) begin
            settle();
            calm = (phase_count >= 3 && phase_count <= 5);

            case ($urandom_range(0, 9))
                0: depth_sel = bhq_pkg::DEPTH_MIN;
                1: depth_sel = bhq_pkg::DEPTH_MAX;
                2: depth_sel = $urandom_range(0, 1)
                             ? bhq_pkg::BIT_DEPTH_W'($urandom_range(0, 1))
                             : bhq_pkg::BIT_DEPTH_W'($urandom_range(17, 31));
                default: depth_sel = bhq_pkg::BIT_DEPTH_W'($urandom_range(2, 16));
            endcase
            which = $urandom_range(0, 3);
            if (which != 1) begin
                cfg = t_cfg_data'($urandom());
                cfg[bhq_pkg::BIT_DEPTH_W-1:0] = depth_sel;
                write_reg(bhq_pkg::REG_BIT_DEPTH, cfg);
            end
            if (which != 0) begin
                case ($urandom_range(0, 9))
                    0: cfg = 8'd1;
                    1: cfg = 8'd255;
                    2: cfg = 8'd0;
                    3: cfg = t_cfg_data'($urandom_range(1, 255));
                    default: cfg = t_cfg_data'($urandom_range(2, 6));
                endcase
                write_reg(bhq_pkg::REG_HOLD_FACTOR, cfg);
            end

            n_items = $urandom_range(20, 70);
            repeat (n_items) push_sample(pick_sample(), 1'b0, '0);
            phase_count++;
        end
        calm = 1'b0;
        settle();

        $display("Sent %0d samples in %0d random phases after the directed table.",
                 items_sent, phase_count);
        $display("Checked %0d fresh and %0d held outputs across %0d register writes.",
                 fresh_seen, held_seen, reg_writes);
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d output items failed", fault_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
